>>> design/assert_macros.svh
// Assertion helpers included by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> design/tksil_pkg.sv
package tksil_pkg;

    localparam int SCORE_W     = 32;
    localparam int TAG_IN_W    = 16;
    localparam int TAG_WIDE_W  = 32;
    localparam int RRANK_W     = 3;
    localparam int RANK_OUT_W  = 3;
    localparam int CNT_OUT_W   = 4;
    localparam int CFG_W       = 4;
    localparam int OPCODE_W    = 2;
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 64;

    localparam logic [CFG_W-1:0] MAX_KEPT_RESET = 4'd8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_READ   = 2'd2,
        OP_NOP    = 2'd3
    } t_opcode;

    typedef struct packed {
        logic                      shift_en;
        logic signed [SCORE_W-1:0] score;
    } t_cell_ctl;

endpackage

>>> design/tksil_cell.sv
module tksil_cell #(
    parameter int TAG_W = 16
) (
    input  logic                               i_clk,
    input  tksil_pkg::t_cell_ctl               i_ctl,
    input  logic [TAG_W-1:0]                   i_new_tag,
    input  logic                               i_in_use,
    input  logic                               i_prev_at_after,
    input  logic signed [tksil_pkg::SCORE_W-1:0] i_prev_score,
    input  logic [TAG_W-1:0]                   i_prev_tag,
    output logic                               o_at_after,
    output logic signed [tksil_pkg::SCORE_W-1:0] o_score,
    output logic [TAG_W-1:0]                   o_tag
);
    import tksil_pkg::*;

    logic signed [SCORE_W-1:0] r_score;
    logic [TAG_W-1:0]          r_tag;

    // The insert point lies at or before this cell once the new score beats it or the cell is empty.
    assign o_at_after = i_prev_at_after || !i_in_use || (i_ctl.score > r_score);
    assign o_score    = r_score;
    assign o_tag      = r_tag;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_en) begin
            if (i_prev_at_after) begin
                r_score <= i_prev_score;
                r_tag   <= i_prev_tag;
            end else if (o_at_after) begin
                r_score <= i_ctl.score;
                r_tag   <= i_new_tag;
            end
        end
    end

endmodule

>>> design/top_k_sorted_insert_list.sv
// A result beat appears in the cycle after its input beat is accepted.
// Throughput: one item per cycle unless the output stalls; cells compare and shift
// in the same cycle, and the output register frees up in the cycle its beat is taken.
// Reset: synchronous, active low; the list becomes empty, max_kept returns to 8
// and the output register is emptied. Stored entries are undefined until written.
module top_k_sorted_insert_list #(
    parameter int DEPTH    = 8,
    parameter int TAG_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tksil_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // score[31:0], tag[47:32], read_rank[50:48], zero fill above
    input  logic [tksil_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode[1:0]
    input  logic [tksil_pkg::OPCODE_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // accepted[0], rank[3:1], count[7:4], entry_valid[8], out_score[40:9],
    // out_tag[56:41], zero fill above
    output logic [tksil_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import tksil_pkg::*;

    `include "assert_macros.svh"

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 4) ? CW : 4;

    logic [CFG_W-1:0]       r_max_kept;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [OUT_TDATA_W-1:0] n_out_data;

    logic                      w_s_fire;
    t_opcode                   w_opcode;
    logic signed [SCORE_W-1:0] w_score;
    logic [TAG_IN_W-1:0]       w_tag_in;
    logic [RRANK_W-1:0]        w_rrank;
    logic [TAG_WIDE_W-1:0]     w_tag_wide;
    logic [TAG_BITS-1:0]       w_tag;

    logic [CW-1:0]   w_lim;
    logic [CW-1:0]   w_p;
    logic            w_full;
    logic            w_accept;
    t_cell_ctl       w_ctl;

    logic [DEPTH-1:0]          w_at_after;
    logic signed [SCORE_W-1:0] w_cell_score [DEPTH];
    logic [TAG_BITS-1:0]       w_cell_tag   [DEPTH];

    assign w_s_fire   = s_axis_tvalid && s_axis_tready;
    assign w_opcode   = t_opcode'(s_axis_tuser);
    assign w_score    = s_axis_tdata[SCORE_W-1:0];
    assign w_tag_in   = s_axis_tdata[SCORE_W+TAG_IN_W-1:SCORE_W];
    assign w_rrank    = s_axis_tdata[SCORE_W+TAG_IN_W+RRANK_W-1:SCORE_W+TAG_IN_W];
    assign w_tag_wide = TAG_WIDE_W'(w_tag_in);
    assign w_tag      = w_tag_wide[TAG_BITS-1:0];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_comb begin
        logic [CMPW-1:0] mk_ext;
        mk_ext = CMPW'(r_max_kept);
        if (mk_ext == '0) begin
            w_lim = CW'(1);
        end else if (mk_ext > CMPW'(DEPTH)) begin
            w_lim = CW'(DEPTH);
        end else begin
            w_lim = mk_ext[CW-1:0];
        end
    end

    always_comb begin
        w_p = CW'(DEPTH);
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (w_at_after[i]) begin
                w_p = CW'(i);
            end
        end
    end

    assign w_full   = (r_count >= w_lim);
    assign w_accept = !w_full || (w_p < w_lim);

    assign w_ctl.shift_en = w_s_fire && (w_opcode == OP_INSERT) && w_accept;
    assign w_ctl.score    = w_score;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic                      prev_at_after;
            logic signed [SCORE_W-1:0] prev_score;
            logic [TAG_BITS-1:0]       prev_tag;

            if (g == 0) begin : g_head
                assign prev_at_after = 1'b0;
                assign prev_score    = w_score;
                assign prev_tag      = w_tag;
            end else begin : g_body
                assign prev_at_after = w_at_after[g-1];
                assign prev_score    = w_cell_score[g-1];
                assign prev_tag      = w_cell_tag[g-1];
            end

            tksil_cell #(
                .TAG_W (TAG_BITS)
            ) u_cell (
                .i_clk           (i_clk),
                .i_ctl           (w_ctl),
                .i_new_tag       (w_tag),
                .i_in_use        (CW'(g) < r_count),
                .i_prev_at_after (prev_at_after),
                .i_prev_score    (prev_score),
                .i_prev_tag      (prev_tag),
                .o_at_after      (w_at_after[g]),
                .o_score         (w_cell_score[g]),
                .o_tag           (w_cell_tag[g])
            );
        end
    endgenerate

    always_comb begin
        logic                      accepted;
        logic [7:0]                p_wide;
        logic [7:0]                cnt_wide;
        logic                      entry_valid;
        logic signed [SCORE_W-1:0] rd_score;
        logic [TAG_WIDE_W-1:0]     rd_tag;

        n_count     = r_count;
        accepted    = 1'b0;
        p_wide      = '0;
        cnt_wide    = '0;
        entry_valid = 1'b0;
        rd_score    = '0;
        rd_tag      = '0;

        case (w_opcode)
            OP_CLEAR: begin
                n_count = '0;
            end
            OP_INSERT: begin
                if (w_accept) begin
                    accepted       = 1'b1;
                    p_wide[CW-1:0] = w_p;
                    n_count        = w_full ? w_lim : CW'(r_count + 1'b1);
                end
            end
            OP_READ: begin
                if (CMPW'(w_rrank) < CMPW'(r_count)) begin
                    entry_valid = 1'b1;
                    for (int i = 0; i < DEPTH; i++) begin
                        if (CMPW'(w_rrank) == CMPW'(i)) begin
                            rd_score               = w_cell_score[i];
                            rd_tag[TAG_BITS-1:0]   = w_cell_tag[i];
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        cnt_wide[CW-1:0] = n_count;
        n_out_data = '0;
        n_out_data[0]     = accepted;
        n_out_data[3:1]   = p_wide[RANK_OUT_W-1:0];
        n_out_data[7:4]   = cnt_wide[CNT_OUT_W-1:0];
        n_out_data[8]     = entry_valid;
        n_out_data[40:9]  = rd_score;
        n_out_data[56:41] = rd_tag[TAG_IN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_kept  <= MAX_KEPT_RESET;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_kept <= i_cfg_wdata;
            end
            if (w_s_fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_fire) begin
            r_out_data <= n_out_data;
        end
    end

    `ASSERT_ALWAYS(a_count_max, i_clk, i_rst_n, r_count <= CW'(DEPTH), "count above depth")
    `ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, w_s_fire && (w_opcode == OP_CLEAR), r_count == '0, "clear did not empty the list")
    `ASSERT_IMPL(a_out_from_in, i_clk, i_rst_n, $rose(r_out_valid), $past(w_s_fire), "result beat without input beat")

    generate
        for (g = 1; g < DEPTH; g++) begin : g_order_chk
            `ASSERT_IMPL(a_sorted, i_clk, i_rst_n, CW'(g) < r_count, w_cell_score[g-1] >= w_cell_score[g], "list out of order")
        end
    endgenerate

endmodule
